// ----- rtl/core/ascp_pkg.sv -----
// Package for the ASCII CAN command parser: command kinds, character codes,
// buffer sizes and small decode helpers.
// No dependencies.
package ascp_pkg;

    // Command kind, also the result kind carried on the output
    typedef enum logic [1:0]
    {
        CMD_FRAME = 2'd0,
        CMD_BAUD  = 2'd1,
        CMD_PORT  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam int BUFFER_BYTES      = 36;
    localparam int MAX_PAYLOAD_BYTES = 8;
    localparam int POS_W             = $clog2(BUFFER_BYTES + 1);
    localparam int TDATA_W           = 144;

    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
    localparam logic [7:0] CH_EQUAL  = 8'h3D;  // '='
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

    localparam logic [2:0] BAUD_DEFAULT = 3'd3;
    localparam logic [2:0] BAUD_250K    = 3'd5;
    localparam logic [2:0] BAUD_500K    = 3'd6;
    localparam logic [2:0] BAUD_1000K   = 3'd7;

    // Lead byte to command kind
    function automatic cmd_t lead_kind(input logic [7:0] b);
        cmd_t k;
        unique case (b)
            CH_HASH:   k = CMD_FRAME;
            CH_DOLLAR: k = CMD_BAUD;
            CH_BANG:   k = CMD_PORT;
            default:   k = CMD_NONE;
        endcase
        return k;
    endfunction

    // Hex digit value, wrapping to 16 bits for non-hex bytes
    function automatic logic [15:0] hex_digit(input logic [7:0] b);
        logic [15:0] v;
        if (b <= CH_NINE)
            v = {8'd0, b} - 16'd48;
        else
            v = {8'd0, b} - 16'd55;
        return v;
    endfunction

    // Expected character of the port query at positions 1..6
    function automatic logic [7:0] listen_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd1:    c = 8'h4C;  // L
            3'd2:    c = 8'h49;  // I
            3'd3:    c = 8'h53;  // S
            3'd4:    c = 8'h54;  // T
            3'd5:    c = 8'h45;  // E
            3'd6:    c = 8'h4E;  // N
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Decimal rate to bit rate code; 100 and anything unknown give the default
    function automatic logic [2:0] baud_map(input logic [13:0] rate);
        logic [2:0] c;
        unique case (rate)
            14'd250:  c = BAUD_250K;
            14'd500:  c = BAUD_500K;
            14'd1000: c = BAUD_1000K;
            default:  c = BAUD_DEFAULT;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/ascii_can_command_parser_core.sv -----
// ASCII CAN command parser core: byte-wise command accumulation and result register.
// Depends on ascp_pkg.
//
// Channel  | Dir | Signals                      | Content
// ---------+-----+------------------------------+----------------------------------
// s_*      | in  | s_tvalid s_tready s_tdata    | one received ASCII byte
// m_*      | out | m_tvalid m_tready m_tdata    | parsed result, kind in m_tuser
//          |     | m_tuser                      |
// cfg_*    | in  | cfg_we cfg_wdata             | hardware identifier byte
//
// One byte per cycle: each transfer updates the accumulators, and a '*' that
// yields a result loads the result register in the same clock.
// The only stall is a '*' arriving while a previous result still waits in the
// output register; other bytes are taken regardless of the master side.
// Reset (rst_n low) clears all parser state and the hardware identifier.
module ascii_can_command_parser_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] frame_ident, [39:32] ext_flag, [47:40] std_flag,
    // [55:48] remote_flag, [63:56] length_code, [127:64] payload,
    // [130:128] baud_code, [138:131] port_ident, [139] overflowed, [143:140] zero
    output logic [143:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata  // [7:0] hardware_ident
);

    localparam int PW = ascp_pkg::POS_W;

    // Parser state
    logic [PW-1:0]       pos_reg,    pos_next;
    ascp_pkg::cmd_t      cmd_reg,    cmd_next;
    logic [31:0]         ident_reg,  ident_next;
    logic [3:0][7:0]     flag_reg,   flag_next;   // ext, std, remote, length
    logic [7:0][7:0]     pay_reg,    pay_next;
    logic [13:0]         dec_reg,    dec_next;
    logic [2:0]          eq_reg,     eq_next;
    logic                listen_reg, listen_next;
    logic                ovf_reg,    ovf_next;
    logic [7:0]          hw_id_reg;

    // Result register
    logic                                  m_valid_reg, m_valid_next;
    logic [ascp_pkg::TDATA_W-1:0]          m_data_reg,  m_data_next;
    logic [1:0]                            m_user_reg,  m_user_next;

    logic                s_xfer;
    logic                is_end;
    logic                at_full;
    logic                do_finish;
    logic                produce;
    ascp_pkg::cmd_t      fin_cmd;
    logic                fin_ovf;
    logic [15:0]         d16;
    logic [15:0]         half_add;
    logic [7:0]          byte_add;
    logic [PW-1:0]       pm9;
    logic [PW-1:0]       pk;
    logic [PW-1:0]       pj;
    logic [17:0]         dec_sum;

    // Result fields
    logic [31:0]         r_ident;
    logic [7:0]          r_ext, r_std, r_rmt, r_len, r_port;
    logic [63:0]         r_pay;
    logic [2:0]          r_baud;
    logic                r_ovf;
    logic [7:0]          keep;

    assign is_end   = (s_tdata == ascp_pkg::CH_STAR);
    // A '*' always ends a command; hold it back only while the output is occupied
    assign s_tready = !m_valid_reg || m_tready || !is_end;
    assign s_xfer   = s_tvalid && s_tready;
    assign at_full  = (pos_reg >= PW'(ascp_pkg::BUFFER_BYTES));

    assign d16      = ascp_pkg::hex_digit(s_tdata);
    // Identifier nibble shift: p=1..4 and p=5..8 both map to 3..0 from p[1:0]
    assign half_add = d16 << {2'(2'd0 - pos_reg[1:0]), 2'b00};
    // Odd positions carry the high nibble of a byte field
    assign byte_add = pos_reg[0] ? {d16[3:0], 4'h0} : d16[7:0];
    assign pm9      = pos_reg - PW'(9);
    assign pk       = pos_reg - PW'(17);
    assign pj       = pk >> 1;
    assign dec_sum  = {1'b0, dec_reg, 3'b000} + {3'b000, dec_reg, 1'b0}
                    + {14'd0, s_tdata[3:0] - ascp_pkg::CH_ZERO[3:0]};

    assign fin_cmd  = (pos_reg == '0) ? ascp_pkg::lead_kind(s_tdata) : cmd_reg;
    assign fin_ovf  = ovf_reg || at_full;

    // Result of a command ending with the current byte
    always_comb
    begin
        r_ident = '0;
        r_ext   = '0;
        r_std   = '0;
        r_rmt   = '0;
        r_len   = '0;
        r_pay   = '0;
        r_baud  = '0;
        r_port  = '0;
        r_ovf   = fin_ovf;
        produce = 1'b1;
        keep    = (flag_reg[3] < 8'(ascp_pkg::MAX_PAYLOAD_BYTES)) ? flag_reg[3]
                                                               : 8'(ascp_pkg::MAX_PAYLOAD_BYTES);
        unique case (fin_cmd)
            ascp_pkg::CMD_FRAME:
            begin
                r_ident = ident_reg;
                r_ext   = flag_reg[0];
                r_std   = flag_reg[1];
                r_rmt   = flag_reg[2];
                r_len   = flag_reg[3];
                for (int j = 0; j < 8; j++)
                begin
                    if (8'(j) < keep)
                        r_pay[8*j +: 8] = pay_reg[j];
                end
                r_ovf = fin_ovf || (flag_reg[3] > 8'(ascp_pkg::MAX_PAYLOAD_BYTES));
            end
            ascp_pkg::CMD_BAUD:
            begin
                r_baud = ascp_pkg::baud_map(dec_reg);
            end
            ascp_pkg::CMD_PORT:
            begin
                // Query must match all six characters
                if (listen_reg && (pos_reg >= PW'(7)))
                    r_port = hw_id_reg;
                else
                    produce = 1'b0;
            end
            default:
            begin
                r_ovf = fin_ovf;
            end
        endcase
    end

    // Accumulator update
    always_comb
    begin
        pos_next    = pos_reg;
        cmd_next    = cmd_reg;
        ident_next  = ident_reg;
        flag_next   = flag_reg;
        pay_next    = pay_reg;
        dec_next    = dec_reg;
        eq_next     = eq_reg;
        listen_next = listen_reg;
        ovf_next    = ovf_reg;
        do_finish   = 1'b0;

        if (s_xfer)
        begin
            if (at_full)
            begin
                // Past the buffer: drop the byte, remember the overflow
                ovf_next  = 1'b1;
                do_finish = is_end;
            end
            else if (pos_reg == '0)
            begin
                cmd_next  = ascp_pkg::lead_kind(s_tdata);
                do_finish = is_end;
                pos_next  = PW'(1);
            end
            else if (is_end)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
                unique case (cmd_reg)
                    ascp_pkg::CMD_FRAME:
                    begin
                        if (pos_reg >= PW'(1) && pos_reg <= PW'(4))
                            ident_next[31:16] = ident_reg[31:16] + half_add;
                        else if (pos_reg >= PW'(5) && pos_reg <= PW'(8))
                            ident_next[15:0] = ident_reg[15:0] + half_add;
                        else if (pos_reg >= PW'(9) && pos_reg <= PW'(16))
                            flag_next[pm9[2:1]] = flag_reg[pm9[2:1]] + byte_add;
                        else if (pj < PW'(ascp_pkg::MAX_PAYLOAD_BYTES))
                            pay_next[pj[2:0]] = pay_reg[pj[2:0]] + byte_add;
                    end
                    ascp_pkg::CMD_BAUD:
                    begin
                        if (eq_reg == 3'd0)
                        begin
                            if (s_tdata == ascp_pkg::CH_EQUAL)
                                eq_next = 3'd1;
                        end
                        else if (eq_reg <= 3'd4)
                        begin
                            if (s_tdata >= ascp_pkg::CH_ZERO && s_tdata <= ascp_pkg::CH_NINE)
                            begin
                                dec_next = dec_sum[13:0];
                                eq_next  = eq_reg + 3'd1;
                            end
                            else
                            begin
                                eq_next = 3'd5;  // digits stop at first non-digit
                            end
                        end
                    end
                    ascp_pkg::CMD_PORT:
                    begin
                        if (pos_reg <= PW'(6) &&
                            s_tdata != ascp_pkg::listen_char(pos_reg[2:0]))
                            listen_next = 1'b0;
                    end
                    default:
                    begin
                        listen_next = listen_reg;
                    end
                endcase
            end

            if (do_finish)
            begin
                pos_next    = '0;
                cmd_next    = ascp_pkg::CMD_FRAME;
                ident_next  = '0;
                flag_next   = '0;
                pay_next    = '0;
                dec_next    = '0;
                eq_next     = '0;
                listen_next = 1'b1;
                ovf_next    = 1'b0;
            end
        end
    end

    // Output register load and drain
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (do_finish && produce)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {4'h0, r_ovf, r_port, r_baud, r_pay,
                            r_len, r_rmt, r_std, r_ext, r_ident};
            m_user_next  = fin_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            cmd_reg     <= ascp_pkg::CMD_FRAME;
            ident_reg   <= '0;
            flag_reg    <= '0;
            pay_reg     <= '0;
            dec_reg     <= '0;
            eq_reg      <= '0;
            listen_reg  <= 1'b1;
            ovf_reg     <= 1'b0;
            hw_id_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            cmd_reg     <= cmd_next;
            ident_reg   <= ident_next;
            flag_reg    <= flag_next;
            pay_reg     <= pay_next;
            dec_reg     <= dec_next;
            eq_reg      <= eq_next;
            listen_reg  <= listen_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
                hw_id_reg <= cfg_wdata;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Assertions
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && is_end |=> pos_reg == '0)
        else $error("position not cleared after terminator");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(ascp_pkg::BUFFER_BYTES))
        else $error("position beyond buffer");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> pos_reg == PW'(ascp_pkg::BUFFER_BYTES))
        else $error("overflow flag without full buffer");

    a_non_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ascp_pkg::CMD_FRAME |-> m_tdata[127:0] == '0)
        else $error("frame fields set on non-frame result");

endmodule

// ----- tb/sv/ascii_can_command_parser_core_tb.sv -----
// Self-checking testbench for ascii_can_command_parser_core: byte stream in, parsed results out,
// compared against a behavioral parser that lives in this file.
// Depends on ascp_pkg and the core RTL.
`timescale 1ns / 100ps

module ascii_can_command_parser_core_tb;

    localparam int IDLE_LIMIT    = 2000;  // cycles with no transfer on either side
    localparam int SETTLE_CYCLES = 16;    // covers a sink stall after the last result
    localparam int PHASE_BYTES   = 400;
    localparam int PHASES        = 4;
    localparam int DIR_ROWS      = 6;

    localparam logic [7:0]  CH_UPPER_A  = 8'h41;
    localparam logic [47:0] LISTEN_WORD = "LISTEN";

    typedef struct packed {
        ascp_pkg::cmd_t kind;
        logic [31:0]    ident;
        logic [7:0]     ext_flag;
        logic [7:0]     std_flag;
        logic [7:0]     remote_flag;
        logic [7:0]     length_code;
        logic [63:0]    payload;
        logic [2:0]     baud_code;
        logic [7:0]     port_ident;
        logic           overflowed;
    } parse_result_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'h00;
    logic         m_tvalid;
    logic         m_tready  = 1'b1;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_we    = 1'b0;
    logic [7:0]   cfg_wdata = 8'h00;

    // Parser model state
    int             at_pos;
    ascp_pkg::cmd_t cur_cmd;
    logic [31:0]    ident_sum;
    logic [7:0]     flag_sum [4];   // ext, std, remote, length
    logic [63:0]    data_sum;
    logic [13:0]    rate_sum;
    int             rate_digits;    // 0 before '=', 1..4 taking digits, 5 done
    bit             listen_ok;
    bit             overrun;
    logic [7:0]     ident_reg;

    parse_result_t pending_results [$];
    logic [7:0]    cmd_bytes [$];

    // Directed table
    string         dir_text  [DIR_ROWS];
    bit            dir_typed [DIR_ROWS];
    parse_result_t dir_want  [DIR_ROWS];
    bit            use_typed = 1'b0;
    parse_result_t typed_result;

    bit no_gaps   = 1'b0;
    int error_count = 0;
    int bytes_sent  = 0;
    int commands    = 0;
    int results_checked = 0;
    int kind_count [4] = '{0, 0, 0, 0};
    int stall_left  = 0;
    int idle_cycles = 0;

    ascii_can_command_parser_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void clear_parser();
        at_pos      = 0;
        cur_cmd     = ascp_pkg::CMD_FRAME;
        ident_sum   = '0;
        for (int i = 0; i < 4; i++)
            flag_sum[i] = '0;
        data_sum    = '0;
        rate_sum    = '0;
        rate_digits = 0;
        listen_ok   = 1'b1;
        overrun     = 1'b0;
    endfunction

    // '*' seen: build the result for the command collected so far, then start over
    function automatic void close_command(output bit got, output parse_result_t res);
        int          len;
        int          keep;
        logic [63:0] mask;
        got      = 1'b1;
        res      = '0;
        res.kind = cur_cmd;
        case (cur_cmd)
            ascp_pkg::CMD_FRAME:
            begin
                len  = flag_sum[3];
                keep = (len < ascp_pkg::MAX_PAYLOAD_BYTES) ? len : ascp_pkg::MAX_PAYLOAD_BYTES;
                mask = (keep >= 8) ? {64{1'b1}} : ((64'd1 << (8 * keep)) - 64'd1);
                res.ident       = ident_sum;
                res.ext_flag    = flag_sum[0];
                res.std_flag    = flag_sum[1];
                res.remote_flag = flag_sum[2];
                res.length_code = flag_sum[3];
                res.payload     = data_sum & mask;
                res.overflowed  = overrun || (len > ascp_pkg::MAX_PAYLOAD_BYTES);
            end
            ascp_pkg::CMD_BAUD:
            begin
                if (rate_sum == 14'd250)
                    res.baud_code = ascp_pkg::BAUD_250K;
                else if (rate_sum == 14'd500)
                    res.baud_code = ascp_pkg::BAUD_500K;
                else if (rate_sum == 14'd1000)
                    res.baud_code = ascp_pkg::BAUD_1000K;
                else
                    res.baud_code = ascp_pkg::BAUD_DEFAULT;
                res.overflowed = overrun;
            end
            ascp_pkg::CMD_PORT:
            begin
                // all six query characters must have arrived and matched
                if (listen_ok && at_pos >= 7)
                begin
                    res.port_ident = ident_reg;
                    res.overflowed = overrun;
                end
                else
                    got = 1'b0;
            end
            default: res.overflowed = overrun;
        endcase
        clear_parser();
    endfunction

    // One accepted byte through the model; got is set when a result falls out
    function automatic void parse_byte(input logic [7:0] b, output bit got,
                                       output parse_result_t res);
        logic [15:0] digit;
        logic [15:0] shifted;
        int          k;
        int          j;
        got   = 1'b0;
        res   = '0;
        // non-hex bytes just wrap, same arithmetic either way
        digit = (b <= ascp_pkg::CH_NINE) ? ({8'h00, b} - 16'd48) : ({8'h00, b} - 16'd55);
        if (at_pos >= ascp_pkg::BUFFER_BYTES)
        begin
            overrun = 1'b1;
            if (b == ascp_pkg::CH_STAR)
                close_command(got, res);
        end
        else if (at_pos == 0)
        begin
            case (b)
                ascp_pkg::CH_HASH:   cur_cmd = ascp_pkg::CMD_FRAME;
                ascp_pkg::CH_DOLLAR: cur_cmd = ascp_pkg::CMD_BAUD;
                ascp_pkg::CH_BANG:   cur_cmd = ascp_pkg::CMD_PORT;
                default:             cur_cmd = ascp_pkg::CMD_NONE;
            endcase
            if (b == ascp_pkg::CH_STAR)
                close_command(got, res);
            else
                at_pos = 1;
        end
        else if (b == ascp_pkg::CH_STAR)
            close_command(got, res);
        else
        begin
            case (cur_cmd)
                ascp_pkg::CMD_FRAME:
                begin
                    if (at_pos <= 4)
                    begin
                        shifted = digit << (4 * (4 - at_pos));
                        ident_sum[31:16] += shifted;
                    end
                    else if (at_pos <= 8)
                    begin
                        shifted = digit << (4 * (8 - at_pos));
                        ident_sum[15:0] += shifted;
                    end
                    else
                    begin
                        // flags at 9..16, data bytes from 17, high nibble first
                        k       = (at_pos <= 16) ? at_pos - 9 : at_pos - 17;
                        j       = k >> 1;
                        shifted = digit << ((k % 2 == 1) ? 0 : 4);
                        if (at_pos <= 16)
                            flag_sum[j] += shifted[7:0];
                        else if (j < ascp_pkg::MAX_PAYLOAD_BYTES && j < 8)
                            data_sum[8 * j +: 8] += shifted[7:0];
                    end
                end
                ascp_pkg::CMD_BAUD:
                begin
                    if (rate_digits == 0)
                    begin
                        if (b == ascp_pkg::CH_EQUAL)
                            rate_digits = 1;
                    end
                    else if (rate_digits <= 4)
                    begin
                        if (b >= ascp_pkg::CH_ZERO && b <= ascp_pkg::CH_NINE)
                        begin
                            rate_sum = 14'(rate_sum * 10 + (b - ascp_pkg::CH_ZERO));
                            rate_digits++;
                        end
                        else
                            rate_digits = 5;
                    end
                end
                ascp_pkg::CMD_PORT:
                begin
                    if (at_pos <= 6 && b != LISTEN_WORD[8 * (6 - at_pos) +: 8])
                        listen_ok = 1'b0;
                end
                default: ;
            endcase
            at_pos++;
        end
    endfunction

    task automatic report_error(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        $display("ERROR result %0d %s: got 0x%0h, want 0x%0h", results_checked, what, got, want);
        error_count++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_error(what, got, want);
    endtask

    // Random byte that cannot end a command
    function automatic logic [7:0] any_but_star();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == ascp_pkg::CH_STAR);
        return c;
    endfunction

    // Appends n hex digits of v, most significant first; now and then a junk digit
    function automatic void push_hex(input logic [31:0] v, input int n);
        logic [3:0] nib;
        logic [7:0] c;
        for (int i = n - 1; i >= 0; i--)
        begin
            nib = v[4 * i +: 4];
            if ($urandom_range(0, 24) == 0)
                c = any_but_star();
            else
                c = (nib < 4'd10) ? 8'(ascp_pkg::CH_ZERO + nib)
                                  : 8'(CH_UPPER_A + nib - 8'd10);
            cmd_bytes.push_back(c);
        end
    endfunction

    // Fills cmd_bytes with one command: mostly well-formed, some broken or oversized
    function automatic void make_command();
        int          sel;
        int          len;
        int          nbytes;
        int          rate;
        int          cut;
        logic [31:0] ident;
        string       text;
        cmd_bytes.delete();
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            cmd_bytes.push_back(ascp_pkg::CH_HASH);
            case ($urandom_range(0, 9))
                0:       ident = 32'h0000_0000;
                1:       ident = 32'hFFFF_FFFF;
                default: ident = $urandom;
            endcase
            push_hex(ident, 8);
            repeat (3) push_hex($urandom_range(0, 255), 2);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
            push_hex(len, 2);
            nbytes = (len <= 8) ? len : $urandom_range(0, 9);
            repeat (nbytes) push_hex($urandom_range(0, 255), 2);
        end
        else if (sel < 65)
        begin
            cmd_bytes.push_back(ascp_pkg::CH_DOLLAR);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) cmd_bytes.push_back(any_but_star());
            if ($urandom_range(0, 9) != 0)
            begin
                cmd_bytes.push_back(ascp_pkg::CH_EQUAL);
                case ($urandom_range(0, 5))
                    0:       rate = 100;
                    1:       rate = 250;
                    2:       rate = 500;
                    3:       rate = 1000;
                    default: rate = $urandom_range(0, 99999);
                endcase
                text = $sformatf("%0d", rate);
                if ($urandom_range(0, 5) == 0)
                    text = {"0", text};
                for (int i = 0; i < text.len(); i++)
                    cmd_bytes.push_back(text[i]);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) cmd_bytes.push_back(any_but_star());
        end
        else if (sel < 85)
        begin
            cmd_bytes.push_back(ascp_pkg::CH_BANG);
            for (int i = 0; i < 6; i++)
                cmd_bytes.push_back(LISTEN_WORD[8 * (5 - i) +: 8]);
            if ($urandom_range(0, 4) == 0)
                cmd_bytes[$urandom_range(1, 6)] = any_but_star();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) cmd_bytes.push_back(any_but_star());
        end
        else if ($urandom_range(0, 4) != 0)
        begin
            // unknown lead byte followed by garbage
            cmd_bytes.push_back(any_but_star());
            repeat ($urandom_range(0, 10)) cmd_bytes.push_back(any_but_star());
        end

        if ($urandom_range(0, 9) == 0)
        begin
            // run past the buffer before terminating
            cut = ascp_pkg::BUFFER_BYTES + $urandom_range(0, 6);
            while (cmd_bytes.size() < cut)
                cmd_bytes.push_back(any_but_star());
        end
        else if ($urandom_range(0, 7) == 0 && cmd_bytes.size() > 0)
            repeat ($urandom_range(1, cmd_bytes.size())) void'(cmd_bytes.pop_back());
        cmd_bytes.push_back(ascp_pkg::CH_STAR);
    endfunction

    // Offers one byte and waits for its transfer; the model runs at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        bit            got;
        parse_result_t res;
        if (!no_gaps && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        parse_byte(b, got, res);
        if (got)
            pending_results.push_back(use_typed ? typed_result : res);
    endtask

    // Stop sending, let every pending result drain, then allow for a silent finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ident(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ident_reg  = v;
    endtask

    // Result side: random stall bursts on tready
    always @(posedge clk)
    begin : sink_stall
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (!no_gaps && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        m_tready <= (stall_left == 0);
    end

    // Every result transfer is matched against the oldest pending result
    always @(posedge clk)
    begin : result_check
        parse_result_t seen;
        parse_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.kind        = ascp_pkg::cmd_t'(m_tuser);
            seen.ident       = m_tdata[31:0];
            seen.ext_flag    = m_tdata[39:32];
            seen.std_flag    = m_tdata[47:40];
            seen.remote_flag = m_tdata[55:48];
            seen.length_code = m_tdata[63:56];
            seen.payload     = m_tdata[127:64];
            seen.baud_code   = m_tdata[130:128];
            seen.port_ident  = m_tdata[138:131];
            seen.overflowed  = m_tdata[139];
            if (pending_results.size() == 0)
                report_error("arrived with nothing pending, kind", seen.kind, 0);
            else
            begin
                want = pending_results.pop_front();
                compare_field("result_kind", seen.kind, want.kind);
                compare_field("frame_ident", seen.ident, want.ident);
                compare_field("ext_flag", seen.ext_flag, want.ext_flag);
                compare_field("std_flag", seen.std_flag, want.std_flag);
                compare_field("remote_flag", seen.remote_flag, want.remote_flag);
                compare_field("length_code", seen.length_code, want.length_code);
                compare_field("payload", seen.payload, want.payload);
                compare_field("baud_code", seen.baud_code, want.baud_code);
                compare_field("port_ident", seen.port_ident, want.port_ident);
                compare_field("overflowed", seen.overflowed, want.overflowed);
                compare_field("tdata pad", m_tdata[143:140], 0);
                kind_count[want.kind]++;
            end
            results_checked++;
        end
    end

    // Watchdog: too long without any transfer means the core hung
    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int         phase_start;
        logic [7:0] ident_val;

        // Directed commands; plain outcomes typed in, the rest left to the model
        dir_text[0] = "*";         // bare terminator at position zero
        dir_text[1] = "$=250*";
        dir_text[2] = "!LISTEN*";
        dir_text[3] = "#*";        // frame with every field missing
        dir_text[4] = "Q*";        // unknown lead byte
        dir_text[5] = "!LIS*";     // short query, no reply
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            dir_want[i]  = '0;
            dir_typed[i] = 1'b1;
        end
        dir_want[0].kind       = ascp_pkg::CMD_NONE;
        dir_want[1].kind       = ascp_pkg::CMD_BAUD;
        dir_want[1].baud_code  = ascp_pkg::BAUD_250K;
        dir_want[2].kind       = ascp_pkg::CMD_PORT;
        dir_want[2].port_ident = 8'hFF;
        dir_want[3].kind       = ascp_pkg::CMD_FRAME;
        dir_want[4].kind       = ascp_pkg::CMD_NONE;
        dir_typed[5]           = 1'b0;

        clear_parser();
        ident_reg = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_ident(8'hFF);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            use_typed    = dir_typed[r];
            typed_result = dir_want[r];
            for (int i = 0; i < dir_text[r].len(); i++)
                send_byte(dir_text[r][i]);
            use_typed = 1'b0;
        end

        // Random phases, each under its own identifier; the last one runs without idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0:       ident_val = 8'h00;
                2:       ident_val = 8'hFF;
                default: ident_val = 8'($urandom_range(1, 254));
            endcase
            write_ident(ident_val);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                make_command();
                no_gaps = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
                foreach (cmd_bytes[i])
                    send_byte(cmd_bytes[i]);
                commands++;
            end
        end

        no_gaps = 1'b1;
        settle();
        $display("Sent %0d bytes (%0d random commands) under %0d identifier settings",
                 bytes_sent, commands, PHASES + 1);
        $display("Checked %0d results: %0d frames, %0d rate, %0d port replies, %0d unknown",
                 results_checked, kind_count[ascp_pkg::CMD_FRAME],
                 kind_count[ascp_pkg::CMD_BAUD], kind_count[ascp_pkg::CMD_PORT],
                 kind_count[ascp_pkg::CMD_NONE]);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ascp_pkg.sv
rtl/core/ascii_can_command_parser_core.sv
tb/sv/ascii_can_command_parser_core_tb.sv
